// File: rtl/dtpd_pkg.sv
// Shared types and constants for the dual-tone LED PWM dimmer.
// No dependencies; dtpd_if, dtpd_level and the top level import this package.
`default_nettype none

package dtpd_pkg;

    localparam int NUM_CH     = 3;
    localparam int CH_YELLOW  = 0;
    localparam int CH_NEUTRAL = 1;
    localparam int CH_BLUE    = 2;

    localparam int OP_W   = 3;
    localparam int BRI_W  = 13;
    localparam int WB_W   = 14;
    localparam int DUTY_W = 8;
    localparam int LEV_W  = 9;   // squared levels span 0..256
    localparam int SQ_W   = 2 * BRI_W;

    localparam logic [BRI_W-1:0]        LEVEL_FULL = 13'd4096;
    localparam logic signed [WB_W-1:0]  WB_POS_FULL = 14'sd4096;
    localparam logic signed [WB_W-1:0]  WB_NEG_FULL = -14'sd4096;

    localparam logic [DUTY_W-1:0] MIN_LEVEL_RESET = 8'h3F;
    localparam logic [DUTY_W-1:0] MAX_LEVEL_RESET = 8'hFF;
    localparam logic [DUTY_W-1:0] COMPARE_RESET   = 8'hFF;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_SET    = 3'd1,
        OP_ON     = 3'd2,
        OP_OFF    = 3'd3,
        OP_TOGGLE = 3'd4
    } opcode_t;

    // Squared levels handed from the level stage to the PWM stage
    typedef struct packed {
        logic [LEV_W-1:0] bri_level;
        logic [LEV_W-1:0] wb_level;
        logic             wb_pos;
        logic             wb_neg;
    } level_t;

endpackage

`default_nettype wire

// File: rtl/dtpd_if.sv
// Request and status channels of the dimmer: valid/ready plus payload.
// Depends on dtpd_pkg for field widths.
`default_nettype none

interface dtpd_cmd_if;
    import dtpd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [BRI_W-1:0]        brightness;
    logic signed [WB_W-1:0]  white_balance;

    modport source (output valid, output opcode, output brightness,
                    output white_balance, input ready);
    modport sink   (input valid, input opcode, input brightness,
                    input white_balance, output ready);
    modport monitor (input valid, input ready, input opcode, input brightness,
                     input white_balance);
endinterface

interface dtpd_status_if;
    logic valid;
    logic ready;
    logic yellow_pin;
    logic neutral_pin;
    logic blue_pin;
    logic running;

    modport source (output valid, output yellow_pin, output neutral_pin,
                    output blue_pin, output running, input ready);
    modport sink   (input valid, input yellow_pin, input neutral_pin,
                    input blue_pin, input running, output ready);
    modport monitor (input valid, input ready, input yellow_pin,
                     input neutral_pin, input blue_pin, input running);
endinterface

`default_nettype wire

// File: rtl/dtpd_level.sv
// Brightness and balance to squared levels: saturate, take magnitude, square.
// Depends on dtpd_pkg.
`default_nettype none

module dtpd_level (
    input  wire logic [dtpd_pkg::BRI_W-1:0]       brightness,
    input  wire logic signed [dtpd_pkg::WB_W-1:0] white_balance,
    output dtpd_pkg::level_t                      level
);
    import dtpd_pkg::*;

    logic [BRI_W-1:0]       bri_sat;
    logic signed [WB_W-1:0] wb_sat;
    logic signed [WB_W-1:0] wb_neg_val;
    logic [BRI_W-1:0]       wb_mag;
    logic [SQ_W-1:0]        bri_sq;
    logic [SQ_W-1:0]        wb_sq;

    always_comb
    begin
        bri_sat = (brightness > LEVEL_FULL) ? LEVEL_FULL : brightness;

        if (white_balance > WB_POS_FULL)
        begin
            wb_sat = WB_POS_FULL;
        end
        else if (white_balance < WB_NEG_FULL)
        begin
            wb_sat = WB_NEG_FULL;
        end
        else
        begin
            wb_sat = white_balance;
        end

        wb_neg_val = -wb_sat;
        wb_mag     = wb_sat[WB_W-1] ? wb_neg_val[BRI_W-1:0] : wb_sat[BRI_W-1:0];

        bri_sq = {{BRI_W{1'b0}}, bri_sat} * {{BRI_W{1'b0}}, bri_sat};
        wb_sq  = {{BRI_W{1'b0}}, wb_mag} * {{BRI_W{1'b0}}, wb_mag};

        // keep bits 24..16: floor(v*v / 65536)
        level.bri_level = bri_sq[16 +: LEV_W];
        level.wb_level  = wb_sq[16 +: LEV_W];
        level.wb_pos    = !wb_sat[WB_W-1] && (wb_sat != '0);
        level.wb_neg    = wb_sat[WB_W-1];
    end

endmodule

`default_nettype wire

// File: rtl/dual_tone_led_pwm_dimmer.sv
// Dual-tone LED PWM dimmer, top level: an input register and a status register per request.
// A request's status enters the status register as the request leaves the input register.
// Throughput: one request per cycle unless status stalls; squaring, clamping and the PWM update run in one pass.
// Stalls: a held status holds the input register, and cmd.ready then follows status.ready once it is full.
// Reset (rst_n low, asynchronous) empties both registers, stops counting and
// restores min_level 0x3F, max_level 0xFF and compare values 0xFF.
// Depends on dtpd_pkg, dtpd_if and dtpd_level.
`default_nettype none

module dual_tone_led_pwm_dimmer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dtpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtpd_pkg::DUTY_W-1:0]     cfg_wdata,
    dtpd_cmd_if.sink                             cmd,
    dtpd_status_if.source                        status
);
    import dtpd_pkg::*;

    // Flow control: the status register takes a new status when it is empty
    // or its status is being taken; the input register takes a request when
    // it is empty or its request moves on into the status register.
    logic rdy_out, rdy_in;

    // Configuration registers
    logic [DUTY_W-1:0] min_level_reg, max_level_reg;

    // Input register: captured request
    logic                   in_valid_reg;
    logic [OP_W-1:0]        in_op_reg;
    logic [BRI_W-1:0]       in_bri_reg;
    logic signed [WB_W-1:0] in_wb_reg;

    // Squared levels of the captured request
    level_t           lvl;

    // PWM state
    logic [DUTY_W-1:0] tick_reg, tick_next;
    logic [DUTY_W-1:0] duty_reg [NUM_CH];
    logic [DUTY_W-1:0] duty_next [NUM_CH];
    logic [DUTY_W-1:0] cmp_reg [NUM_CH];
    logic [DUTY_W-1:0] cmp_next [NUM_CH];
    logic [NUM_CH-1:0] pin_reg, pin_next;
    logic              run_reg, run_next;
    logic              armed_reg, armed_next;

    // Status register
    logic              out_valid_reg;
    logic [NUM_CH-1:0] out_pin_reg;
    logic              out_run_reg;

    // Set command arithmetic
    logic [LEV_W-1:0] diff_level;
    logic [LEV_W-1:0] ch_level [NUM_CH];

    function automatic logic [DUTY_W-1:0] clamp_level(
        input logic [LEV_W-1:0]  lv,
        input logic [DUTY_W-1:0] lo,
        input logic [DUTY_W-1:0] hi
    );
        logic [DUTY_W-1:0] res;
        // max test first, so an inverted window ends at one of its bounds
        if (lv > {1'b0, hi})
        begin
            res = hi;
        end
        else if (lv < {1'b0, lo})
        begin
            res = lo;
        end
        else
        begin
            res = lv[DUTY_W-1:0];
        end
        return res;
    endfunction

    assign rdy_out   = !out_valid_reg || status.ready;
    assign rdy_in    = !in_valid_reg || rdy_out;
    assign cmd.ready = rdy_in;

    assign status.valid       = out_valid_reg;
    assign status.yellow_pin  = out_pin_reg[CH_YELLOW];
    assign status.neutral_pin = out_pin_reg[CH_NEUTRAL];
    assign status.blue_pin    = out_pin_reg[CH_BLUE];
    assign status.running     = out_run_reg;

    // Configuration: to be written only while idle, so no hazard against the pipe; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= MIN_LEVEL_RESET;
            max_level_reg <= MAX_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_LEVEL: min_level_reg <= cfg_wdata;
                CFG_MAX_LEVEL: max_level_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Input register: capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rdy_in)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_in)
        begin
            in_op_reg  <= cmd.opcode;
            in_bri_reg <= cmd.brightness;
            in_wb_reg  <= cmd.white_balance;
        end
    end

    // Square both inputs of the captured request
    dtpd_level u_level (
        .brightness    (in_bri_reg),
        .white_balance (in_wb_reg),
        .level         (lvl)
    );

    // Per-channel levels for a set: dim the balance side, never below zero
    always_comb
    begin
        diff_level = (lvl.bri_level > lvl.wb_level) ?
                     (lvl.bri_level - lvl.wb_level) : '0;
        ch_level[CH_NEUTRAL] = lvl.bri_level;
        ch_level[CH_YELLOW]  = lvl.wb_pos ? diff_level : lvl.bri_level;
        ch_level[CH_BLUE]    = lvl.wb_neg ? diff_level : lvl.bri_level;
    end

    always_comb
    begin
        tick_next  = tick_reg;
        pin_next   = pin_reg;
        run_next   = run_reg;
        armed_next = armed_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            duty_next[i] = duty_reg[i];
            cmp_next[i]  = cmp_reg[i];
        end

        case (in_op_reg)
            OP_TICK:
            begin
                if (run_reg)
                begin
                    tick_next = tick_reg + 1'b1;
                    // wrap raises armed pins before the compare lowers them
                    if ((tick_next == '0) && armed_reg)
                    begin
                        pin_next = '1;
                    end
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (tick_next == cmp_reg[i])
                        begin
                            pin_next[i] = 1'b0;
                            cmp_next[i] = duty_reg[i];
                        end
                    end
                end
            end
            OP_SET:
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    duty_next[i] = clamp_level(ch_level[i], min_level_reg, max_level_reg);
                end
                armed_next = 1'b1;
            end
            OP_ON:
            begin
                run_next = 1'b1;
            end
            OP_OFF:
            begin
                pin_next = '0;
                run_next = 1'b0;
            end
            OP_TOGGLE:
            begin
                if (run_reg)
                begin
                    pin_next = '0;
                    run_next = 1'b0;
                end
                else
                begin
                    run_next = 1'b1;
                end
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
    end

    // Advance the PWM state only as a request leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            pin_reg   <= '0;
            run_reg   <= 1'b0;
            armed_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                duty_reg[i] <= '0;
                cmp_reg[i]  <= COMPARE_RESET;
            end
        end
        else if (in_valid_reg && rdy_out)
        begin
            tick_reg  <= tick_next;
            pin_reg   <= pin_next;
            run_reg   <= run_next;
            armed_reg <= armed_next;
            for (int i = 0; i < NUM_CH; i++)
            begin
                duty_reg[i] <= duty_next[i];
                cmp_reg[i]  <= cmp_next[i];
            end
        end
    end

    // Status register: hold until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy_out)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out && in_valid_reg)
        begin
            out_pin_reg <= pin_next;
            out_run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dtpd_checker.sv
// Port-level checks for the dimmer, bound to the top level.
// Depends on the request and status ports of dual_tone_led_pwm_dimmer.
`default_nettype none

module dtpd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic status_valid,
    input wire logic status_ready,
    input wire logic yellow_pin,
    input wire logic neutral_pin,
    input wire logic blue_pin,
    input wire logic running
);

    // A stalled status holds its value
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (status_valid && !status_ready) |=>
        (status_valid && $stable(yellow_pin) && $stable(neutral_pin)
         && $stable(blue_pin) && $stable(running)))
    else $error("status changed while stalled");

    // Pins can only be driven while counting runs
    a_dark_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (status_valid && !running) |->
        (!yellow_pin && !neutral_pin && !blue_pin))
    else $error("pin high while stopped");

    // An empty status register means the pipe can take a request
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !status_valid |-> cmd_ready)
    else $error("request stalled with no status pending");

    // Nothing appears at the output without a request going in earlier
    a_no_spurious_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_valid && !status_valid) ##1 (!cmd_valid && !status_valid)
        ##1 !cmd_valid |=> !status_valid)
    else $error("status without request");

endmodule

bind dual_tone_led_pwm_dimmer dtpd_checker u_dtpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .status_valid (status.valid),
    .status_ready (status.ready),
    .yellow_pin   (status.yellow_pin),
    .neutral_pin  (status.neutral_pin),
    .blue_pin     (status.blue_pin),
    .running      (status.running)
);

`default_nettype wire
